// ----- src/chs_pkg.sv -----
package chs_pkg;

  localparam int MAP_W            = 37;
  localparam int CH_W             = 6;
  localparam int EC_W             = 16;
  localparam int AA_W             = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 37;
  localparam int OUT_TDATA_W      = 8;
  localparam int DEF_NUM_CHANNELS = 37;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCESS_ADDR = 2'd0,
    REG_CHANNEL_MAP = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [EC_W-1:0]             ident;
    logic [MAP_W-1:0]            mask;
    logic [CH_W-1:0]             count;
    logic [MAP_W-1:0][CH_W-1:0]  prefix;
  } chs_cfg_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

  // One round: reverse the bits of each byte, multiply by 17, add the identifier.
  function automatic logic [EC_W-1:0] prn_round(input logic [EC_W-1:0] u,
                                                input logic [EC_W-1:0] ident);
    logic [EC_W-1:0] s;
    s = {rev8(u[15:8]), rev8(u[7:0])};
    return s + {s[EC_W-5:0], 4'b0000} + ident;
  endfunction

endpackage

// ----- src/chs_cfg.sv -----
module chs_cfg #(
  parameter int NUM_CHANNELS = chs_pkg::DEF_NUM_CHANNELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [chs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [chs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output chs_pkg::chs_cfg_t               cfg_o
);
  import chs_pkg::*;

  logic [AA_W-1:0]             aa_r;
  logic [MAP_W-1:0]            map_r;
  logic [MAP_W-1:0]            mask_nxt;
  logic [MAP_W-1:0]            mask_r;
  logic [CH_W-1:0]             count_nxt;
  logic [CH_W-1:0]             count_r;
  logic [MAP_W-1:0][CH_W-1:0]  prefix_nxt;
  logic [MAP_W-1:0][CH_W-1:0]  prefix_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aa_r  <= '0;
      map_r <= '1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ACCESS_ADDR: aa_r  <= cfg_data[AA_W-1:0];
        REG_CHANNEL_MAP: map_r <= cfg_data[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MAP_W; i++) begin
      mask_nxt[i] = map_r[i] && (i < NUM_CHANNELS);
    end
  end

  // Number of used channels below each channel, for the remapping search.
  always_comb begin
    logic [MAP_W-1:0] lowm;
    for (int i = 0; i < MAP_W; i++) begin
      lowm          = (MAP_W'(1) << i) - MAP_W'(1);
      prefix_nxt[i] = CH_W'($countones(mask_nxt & lowm));
    end
    count_nxt = CH_W'($countones(mask_nxt));
  end

  always_ff @(posedge clk) begin
    mask_r   <= mask_nxt;
    count_r  <= count_nxt;
    prefix_r <= prefix_nxt;
  end

  assign cfg_o.ident  = aa_r[EC_W-1:0] ^ aa_r[AA_W-1:EC_W];
  assign cfg_o.mask   = mask_r;
  assign cfg_o.count  = count_r;
  assign cfg_o.prefix = prefix_r;

endmodule

// ----- src/chs_prn.sv -----
module chs_prn (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ce,
  input  logic                     valid_i,
  input  logic [chs_pkg::EC_W-1:0] counter_i,
  input  logic [chs_pkg::EC_W-1:0] ident_i,
  output logic                     valid_o,
  output logic [chs_pkg::EC_W-1:0] prn_o
);
  import chs_pkg::*;

  logic            v1_r, v2_r, v3_r;
  logic [EC_W-1:0] x1_r, x2_r, prn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (ce) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r  <= prn_round(counter_i ^ ident_i, ident_i);
      x2_r  <= prn_round(x1_r, ident_i);
      prn_r <= prn_round(x2_r, ident_i) ^ ident_i;
    end
  end

  assign valid_o = v3_r;
  assign prn_o   = prn_r;

endmodule

// ----- src/chs_sel.sv -----
module chs_sel #(
  parameter int NUM_CHANNELS = chs_pkg::DEF_NUM_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     ce,
  input  logic                     valid_i,
  input  logic [chs_pkg::EC_W-1:0] prn_i,
  input  chs_pkg::chs_cfg_t        cfg_i,
  output logic                     valid_o,
  output logic [chs_pkg::CH_W-1:0] channel_o,
  output logic                     no_channel_o
);
  import chs_pkg::*;

  localparam int RECIP_SH = 22;
  localparam int RECIP    = (1 << RECIP_SH) / NUM_CHANNELS;
  localparam int QP_W     = EC_W + RECIP_SH;
  localparam int KP_W     = EC_W + CH_W;
  localparam int SEL_W    = 1 << CH_W;

  logic [QP_W-1:0]   qprod;
  logic [KP_W-1:0]   kprod;
  logic [EC_W-1:0]   qn;
  logic [EC_W-1:0]   rraw;
  logic [EC_W-1:0]   rcor;
  logic [SEL_W-1:0]  mask_ext;
  logic              hit;
  logic [CH_W-1:0]   remap_ch;
  logic [CH_W-1:0]   chan_nxt;

  logic              v4_r, v5_r, out_valid_r;
  logic [EC_W-1:0]   prn4_r, q4_r;
  logic [CH_W-1:0]   k4_r, k5_r, r5_r, chan_r;
  logic              empty4_r, empty5_r, no_channel_r;

  // Remainder by a reciprocal estimate that is at most one below the quotient.
  assign qprod = QP_W'(prn_i) * QP_W'(RECIP);
  assign kprod = KP_W'(prn_i) * KP_W'(cfg_i.count);

  assign qn   = EC_W'(q4_r * EC_W'(NUM_CHANNELS));
  assign rraw = prn4_r - qn;
  assign rcor = (rraw >= EC_W'(NUM_CHANNELS)) ? rraw - EC_W'(NUM_CHANNELS) : rraw;

  assign mask_ext = SEL_W'(cfg_i.mask);
  assign hit      = mask_ext[r5_r];

  always_comb begin
    remap_ch = '0;
    for (int i = 0; i < MAP_W; i++) begin
      if (cfg_i.mask[i] && (cfg_i.prefix[i] == k5_r)) begin
        remap_ch = remap_ch | CH_W'(i);
      end
    end
  end

  always_comb begin
    if (empty5_r) begin
      chan_nxt = '0;
    end else if (hit) begin
      chan_nxt = r5_r;
    end else begin
      chan_nxt = remap_ch;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      v4_r        <= valid_i;
      v5_r        <= v4_r;
      out_valid_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      prn4_r       <= prn_i;
      q4_r         <= qprod[QP_W-1:RECIP_SH];
      k4_r         <= kprod[KP_W-1:EC_W];
      empty4_r     <= (cfg_i.count == '0);
      r5_r         <= rcor[CH_W-1:0];
      k5_r         <= k4_r;
      empty5_r     <= empty4_r;
      chan_r       <= chan_nxt;
      no_channel_r <= empty5_r;
    end
  end

  assign valid_o      = out_valid_r;
  assign channel_o    = chan_r;
  assign no_channel_o = no_channel_r;

`ifndef NO_ASSERTIONS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (r5_r < NUM_CHANNELS))
    else $error("channel remainder out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && no_channel_r) |-> (chan_r == '0))
    else $error("empty map must give channel zero");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !no_channel_r) |-> (chan_r < NUM_CHANNELS))
    else $error("selected channel out of range");
`endif

endmodule

// ----- src/ble_channel_select_alg2_top.sv -----
// Bluetooth LE data channel selection (algorithm 2): each event counter transfer on the input
// yields one channel transfer on the output. The block is a six-stage pipeline (three stages
// for the pseudo-random rounds, two for the reciprocal remainder and the remap index, one for
// the map lookup and remapping), so it takes one counter every clock cycle while the output is
// not stalled; a stall on the output freezes every stage.
// The channel identifier, used-channel count and per-channel prefix counts are derived from
// the configuration registers, so configuration writes must be made while no transfer is in
// flight.
module ble_channel_select_alg2_top #(
  parameter int NUM_CHANNELS = chs_pkg::DEF_NUM_CHANNELS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [chs_pkg::EC_W-1:0]         in_tdata,   // [15:0] event_counter
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [chs_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [5:0] channel, [7:6] zero
  output logic [0:0]                       out_tuser,  // [0] no_channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [chs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [chs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import chs_pkg::*;

  chs_cfg_t        cfg;
  logic            ce;
  logic            prn_valid;
  logic [EC_W-1:0] prn;
  logic [CH_W-1:0] channel;
  logic            no_channel;

  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  chs_cfg #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_o     (cfg)
  );

  chs_prn u_prn (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .valid_i   (in_tvalid),
    .counter_i (in_tdata),
    .ident_i   (cfg.ident),
    .valid_o   (prn_valid),
    .prn_o     (prn)
  );

  chs_sel #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_sel (
    .clk          (clk),
    .rst_n        (rst_n),
    .ce           (ce),
    .valid_i      (prn_valid),
    .prn_i        (prn),
    .cfg_i        (cfg),
    .valid_o      (out_tvalid),
    .channel_o    (channel),
    .no_channel_o (no_channel)
  );

  assign out_tdata = {{(OUT_TDATA_W-CH_W){1'b0}}, channel};
  assign out_tuser = no_channel;

endmodule
